[design/slsfr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package slsfr_pkg;

  // Receiver phase
  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_LEN  = 2'd1,
    PH_DATA = 2'd2,
    PH_SUM  = 2'd3
  } phase_t;

  // Result kinds
  typedef enum logic [2:0] {
    KIND_PAYLOAD = 3'd0,
    KIND_GOOD    = 3'd1,
    KIND_BADSUM  = 3'd2,
    KIND_LENERR  = 3'd3,
    KIND_TIMEOUT = 3'd4
  } kind_t;

  // Input word kind (tuser)
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] CFG_HEAD_BYTE     = 2'd0;
  localparam logic [1:0] CFG_MAX_PAYLOAD   = 2'd1;
  localparam logic [1:0] CFG_TIMEOUT_TICKS = 2'd2;

  // Reset values of the configuration registers
  localparam logic [7:0] HEAD_BYTE_RST     = 8'hFE;
  localparam logic [7:0] MAX_PAYLOAD_RST   = 8'd99;
  localparam logic [7:0] TIMEOUT_TICKS_RST = 8'd10;

  typedef struct packed {
    logic [7:0] head_byte;
    logic [7:0] max_payload;
    logic [7:0] timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic       valid;
    kind_t      kind;
    logic [7:0] payload_byte;
    logic [7:0] byte_index;
  } res_t;

endpackage

`default_nettype wire

[design/slsfr_core.sv]
`timescale 1ns / 1ps
`default_nettype none

module slsfr_core import slsfr_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       step,        // process one word this cycle
  input  wire logic       op,
  input  wire logic [7:0] data_byte,
  input  wire cfg_t       cfg,
  output res_t            res
);

  phase_t     phase, phase_next;
  logic [7:0] frame_length, frame_length_next;
  logic [7:0] bytes_seen, bytes_seen_next;
  logic [7:0] running_sum, running_sum_next;
  logic [7:0] tick_count, tick_count_next;
  logic [7:0] tick_inc;
  logic [7:0] seen_inc;

  // Frame state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HUNT;
      frame_length <= '0;
      bytes_seen   <= '0;
      running_sum  <= '0;
      tick_count   <= '0;
    end else if (step) begin
      phase        <= phase_next;
      frame_length <= frame_length_next;
      bytes_seen   <= bytes_seen_next;
      running_sum  <= running_sum_next;
      tick_count   <= tick_count_next;
    end
  end

  assign tick_inc = (tick_count == 8'hFF) ? tick_count : tick_count + 8'd1;
  assign seen_inc = bytes_seen + 8'd1;

  // Next state and result
  always_comb begin
    phase_next        = phase;
    frame_length_next = frame_length;
    bytes_seen_next   = bytes_seen;
    running_sum_next  = running_sum;
    tick_count_next   = tick_count;
    res.valid         = 1'b0;
    res.kind          = KIND_PAYLOAD;
    res.payload_byte  = '0;
    res.byte_index    = '0;

    if (op == OP_TICK) begin
      // ticks only count while a frame is open
      if (phase != PH_HUNT) begin
        tick_count_next = tick_inc;
        if (tick_inc >= cfg.timeout_ticks) begin
          tick_count_next   = '0;
          phase_next        = PH_HUNT;
          frame_length_next = '0;
          bytes_seen_next   = '0;
          running_sum_next  = '0;
          res.valid         = 1'b1;
          res.kind          = KIND_TIMEOUT;
          res.byte_index    = frame_length;
        end
      end
    end else begin
      case (phase)
        PH_HUNT: begin
          if (data_byte == cfg.head_byte) begin
            phase_next      = PH_LEN;
            tick_count_next = '0;
          end
        end
        PH_LEN: begin
          if (data_byte == 8'd0) begin
            phase_next = PH_HUNT;
          end else if (data_byte > cfg.max_payload) begin
            phase_next     = PH_HUNT;
            res.valid      = 1'b1;
            res.kind       = KIND_LENERR;
            res.byte_index = data_byte;
          end else begin
            frame_length_next = data_byte;
            bytes_seen_next   = '0;
            running_sum_next  = '0;
            phase_next        = PH_DATA;
          end
        end
        PH_DATA: begin
          running_sum_next = running_sum + data_byte;
          bytes_seen_next  = seen_inc;
          if (seen_inc >= frame_length) begin
            phase_next = PH_SUM;
          end
          res.valid        = 1'b1;
          res.kind         = KIND_PAYLOAD;
          res.payload_byte = data_byte;
          res.byte_index   = bytes_seen;
        end
        default: begin
          // checksum byte closes the frame
          phase_next        = PH_HUNT;
          frame_length_next = '0;
          bytes_seen_next   = '0;
          running_sum_next  = '0;
          res.valid         = 1'b1;
          res.kind          = (data_byte == running_sum) ? KIND_GOOD : KIND_BADSUM;
          res.byte_index    = frame_length;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  // hunting always starts from a clean frame
  a_hunt_clean: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_HUNT) |-> (frame_length == 8'd0 && bytes_seen == 8'd0 &&
                            running_sum == 8'd0))
    else $error("frame state not cleared while hunting");

  // inside a payload the count never passes the length
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DATA || phase == PH_SUM) |->
      (frame_length != 8'd0 && bytes_seen <= frame_length))
    else $error("bytes_seen out of range");

  // checksum phase is entered only with the full payload seen
  a_sum_full: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_SUM) |-> (bytes_seen == frame_length))
    else $error("checksum phase with payload incomplete");

  // a processed payload byte leaves the frame in data or checksum phase
  a_payload_step: assert property (@(posedge clk) disable iff (rst)
    (step && res.valid && res.kind == KIND_PAYLOAD) |=>
      (phase == PH_DATA || phase == PH_SUM))
    else $error("payload result outside a frame");
`endif

endmodule

`default_nettype wire

[design/sync_length_sum_frame_receiver.sv]
`timescale 1ns / 1ps
`default_nettype none

// Sync-byte, length-prefixed frame receiver with an 8-bit additive checksum.
// Input stream s_axis: one word per received byte (tuser 0, byte in tdata)
// or per time tick (tuser 1, tdata ignored).
// Output stream m_axis: payload bytes with their index, then one status word
// per frame (good, bad checksum, length error or timeout); payload is zero on
// status words and tdata[15:8] carries the frame length.
// Configuration: cfg_valid/cfg_ready with cfg_index 0 head byte, 1 max
// payload, 2 timeout ticks; index 3 is ignored. cfg_ready is always high;
// write only while the block is idle.
// Path: a word accepted into the input register is processed by the core, and
// its result is registered in the output register and presented on m_axis.
// Throughput: one word per cycle while m_axis is not stalled; a single
// compare/add stage sits between the input register and the output register.
// Stall: when m_axis is held with a result pending, the input register fills
// and s_axis_tready drops until the output word is taken.
// Reset (rst, synchronous): hunting for the head byte, counters cleared,
// configuration back to 0xFE / 99 / 10, both stream registers empty.

module sync_length_sum_frame_receiver import slsfr_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  wire logic        s_axis_tuser,   // [0] operation
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // [7:0] payload_byte, [15:8] byte_index
  output logic [2:0]       m_axis_tuser,   // [2:0] result_kind
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data
);

  cfg_t       cfg;
  logic       in_valid;
  logic       in_op;
  logic [7:0] in_byte;
  logic       advance;
  res_t       res;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.head_byte     <= HEAD_BYTE_RST;
      cfg.max_payload   <= MAX_PAYLOAD_RST;
      cfg.timeout_ticks <= TIMEOUT_TICKS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_HEAD_BYTE:     cfg.head_byte     <= cfg_data;
        CFG_MAX_PAYLOAD:   cfg.max_payload   <= cfg_data;
        CFG_TIMEOUT_TICKS: cfg.timeout_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  // The input stage moves on when the output register is free or being drained
  assign advance       = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = !in_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_op   <= s_axis_tuser;
      in_byte <= s_axis_tdata;
    end
  end

  slsfr_core u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (in_valid && advance),
    .op        (in_op),
    .data_byte (in_byte),
    .cfg       (cfg),
    .res       (res)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= in_valid && res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid && res.valid) begin
      m_axis_tdata <= {res.byte_index, res.payload_byte};
      m_axis_tuser <= res.kind;
    end
  end

endmodule

`default_nettype wire

[tb/sv/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import slsfr_pkg::*;

  // Index past the last register; writes to it must change nothing
  localparam logic [1:0] CFG_SPARE = 2'd3;

  typedef struct packed {
    logic       op;
    logic [7:0] value;
  } rx_word_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] payload;
    logic [7:0] pos;
  } frame_result_t;

  // Frame tracker: follows the receiver word by word and checks what comes out
  class frame_checker;
    logic [7:0] head;
    logic [7:0] len_limit;
    logic [7:0] tick_limit;
    phase_t     phase;
    logic [7:0] frame_len;
    logic [7:0] seen;
    logic [7:0] sum;
    logic [7:0] ticks;
    frame_result_t pending_results[$];
    int errors;

    function new();
      head       = HEAD_BYTE_RST;
      len_limit  = MAX_PAYLOAD_RST;
      tick_limit = TIMEOUT_TICKS_RST;
      ticks      = 8'h00;
      errors     = 0;
      drop_frame();
    endfunction

    function void drop_frame();
      phase     = PH_HUNT;
      frame_len = 8'h00;
      seen      = 8'h00;
      sum       = 8'h00;
    endfunction

    function void add_result(kind_t kind, logic [7:0] payload, logic [7:0] pos);
      frame_result_t r;
      r.kind    = kind;
      r.payload = payload;
      r.pos     = pos;
      pending_results.push_back(r);
    endfunction

    function void write_reg(logic [1:0] idx, logic [7:0] value);
      case (idx)
        CFG_HEAD_BYTE:     head = value;
        CFG_MAX_PAYLOAD:   len_limit = value;
        CFG_TIMEOUT_TICKS: tick_limit = value;
        default: ;
      endcase
    endfunction

    // Called for every word the receiver accepts
    function void take_word(logic op, logic [7:0] value);
      if (op == OP_TICK) begin
        // ticks only count while a frame is open
        if (phase == PH_HUNT) return;
        if (ticks != 8'hFF) ticks = ticks + 8'd1;
        if (ticks >= tick_limit) begin
          add_result(KIND_TIMEOUT, 8'h00, frame_len);
          ticks = 8'h00;
          drop_frame();
        end
        return;
      end
      case (phase)
        PH_HUNT: begin
          if (value == head) begin
            phase = PH_LEN;
            ticks = 8'h00;
          end
        end
        PH_LEN: begin
          if (value == 8'h00) begin
            drop_frame();
          end else if (value > len_limit) begin
            drop_frame();
            add_result(KIND_LENERR, 8'h00, value);
          end else begin
            frame_len = value;
            seen      = 8'h00;
            sum       = 8'h00;
            phase     = PH_DATA;
          end
        end
        PH_DATA: begin
          add_result(KIND_PAYLOAD, value, seen);
          sum  = sum + value;
          seen = seen + 8'd1;
          if (seen >= frame_len) phase = PH_SUM;
        end
        default: begin
          add_result((value == sum) ? KIND_GOOD : KIND_BADSUM, 8'h00, frame_len);
          drop_frame();
        end
      endcase
    endfunction

    task report(string what);
      if (errors < 40) $display("MISMATCH: %s", what);
      errors++;
    endtask

    // Called for every word the receiver hands out
    task match_result(logic [2:0] kind, logic [7:0] payload, logic [7:0] pos);
      frame_result_t want;
      if (pending_results.size() == 0) begin
        report($sformatf("unexpected word kind %0d payload %02h index %0d",
                         kind, payload, pos));
        return;
      end
      want = pending_results.pop_front();
      if (kind !== want.kind)
        report($sformatf("kind %0d, want %0d", kind, want.kind));
      if (payload !== want.payload)
        report($sformatf("payload %02h, want %02h", payload, want.payload));
      if (pos !== want.pos)
        report($sformatf("index %0d, want %0d", pos, want.pos));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = 2'd0;
  logic [7:0]  cfg_data = 8'h00;

  frame_checker frames;
  rx_word_t     word_q[$];
  rx_word_t     next_word;
  int           built = 0;
  int           traffic_phase = 0;
  int           burst_left = 0;
  int           gap_left = 0;
  int           sink_cycle = 0;
  int           stall_mode = 0;
  bit           sink_ready;
  bit           hold_off = 1'b0;

  sync_length_sum_frame_receiver dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [7:0] data_byte
    .s_axis_tuser  (s_axis_tuser),   // [0] operation
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // [7:0] payload_byte, [15:8] byte_index
    .m_axis_tuser  (m_axis_tuser),   // [2:0] result_kind
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #1 clk = ~clk;

  // Sender: pops queued words, in bursts with random gaps
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) frames.take_word(s_axis_tuser, s_axis_tdata);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (word_q.size() != 0) begin
          next_word = word_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= next_word.value;
          s_axis_tuser  <= next_word.op;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each word taken, under a stall mode redrawn at random
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready)
        frames.match_result(m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[15:8]);
      sink_cycle++;
      if (sink_cycle % 128 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0:       sink_ready = 1'b1;
        1:       sink_ready = ($urandom_range(0, 3) != 0);
        2:       sink_ready = ($urandom_range(0, 3) == 0);
        default: sink_ready = ((sink_cycle / 3) % 2) == 0;
      endcase
      m_axis_tready <= sink_ready && !hold_off;
    end
  end

  // Long receiver hold-offs so the block backs up into its input
  initial begin : hold_off_gen
    wait (traffic_phase == 1);
    repeat (60) @(negedge clk);
    hold_off = 1'b1;
    repeat (300) @(negedge clk);
    hold_off = 1'b0;
    wait (traffic_phase == 4);
    repeat (40) @(negedge clk);
    hold_off = 1'b1;
    repeat (250) @(negedge clk);
    hold_off = 1'b0;
  end

  initial begin : watchdog
    #1_000_000;
    $display("testbench NOT OK");
    $finish;
  end

  task automatic put_word(input logic op, input logic [7:0] value);
    rx_word_t w;
    w.op    = op;
    w.value = value;
    word_q.push_back(w);
    built++;
  endtask

  // Well-formed frame with the odd tick mixed in; checksum optionally broken
  task automatic put_frame(input logic [7:0] len, input bit corrupt);
    logic [7:0] total;
    logic [7:0] b;
    total = 8'h00;
    put_word(OP_BYTE, frames.head);
    put_word(OP_BYTE, len);
    for (int i = 0; i < int'(len); i++) begin
      if ($urandom_range(0, 9) == 0) put_word(OP_TICK, 8'($urandom_range(0, 255)));
      b = 8'($urandom_range(0, 255));
      total = total + b;
      put_word(OP_BYTE, b);
    end
    if (corrupt) total = total ^ 8'($urandom_range(1, 255));
    put_word(OP_BYTE, total);
  endtask

  // Mostly short lengths; now and then zero, the limit, one past it, or anything
  function automatic logic [7:0] pick_length();
    int r;
    int cap;
    r   = $urandom_range(0, 99);
    cap = (frames.len_limit == 8'd0 || frames.len_limit > 8'd12) ? 12 : int'(frames.len_limit);
    if (r < 4) return 8'd0;
    if (r < 10) return 8'($urandom_range(1, 255));
    if (r < 14) return frames.len_limit;
    if (r < 18) return frames.len_limit + 8'd1;
    return 8'($urandom_range(1, cap));
  endfunction

  task automatic make_traffic(input int target);
    int r;
    int n;
    int k;
    int stop;
    logic [7:0] len;
    stop = built + target;
    while (built < stop) begin
      r = $urandom_range(0, 99);
      if (r < 78) begin
        put_frame(pick_length(), $urandom_range(0, 3) == 0);
      end else if (r < 90) begin
        // line noise: stray bytes and ticks
        n = $urandom_range(1, 4);
        repeat (n) put_word(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
      end else begin
        // frame cut short, usually left to time out
        len = 8'($urandom_range(2, 12));
        put_word(OP_BYTE, frames.head);
        put_word(OP_BYTE, len);
        k = $urandom_range(0, int'(len) - 1);
        repeat (k) put_word(OP_BYTE, 8'($urandom_range(0, 255)));
        n = (frames.tick_limit > 8'd20) ? 20 : int'(frames.tick_limit) + 1;
        repeat (n) put_word(OP_TICK, 8'($urandom_range(0, 255)));
      end
    end
  endtask

  // Wait until every queued word is in and every result is out
  task automatic settle();
    while (word_q.size() != 0 || s_axis_tvalid) @(negedge clk);
    while (frames.pending_results.size() != 0) @(negedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [1:0] idx, input logic [7:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    frames.write_reg(idx, value);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_cfg(input logic [7:0] head, input logic [7:0] max_len,
                          input logic [7:0] ticks);
    write_cfg(CFG_HEAD_BYTE, head);
    write_cfg(CFG_MAX_PAYLOAD, max_len);
    write_cfg(CFG_TIMEOUT_TICKS, ticks);
  endtask

  initial begin : main_seq
    frames = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: tick and stray bytes while hunting, zero length,
    // oversize length, wrapping sum with good checksum, bad checksum
    @(negedge clk);
    put_word(OP_TICK, 8'hA5);
    put_word(OP_BYTE, 8'h00);
    put_word(OP_BYTE, 8'hFF);
    put_word(OP_BYTE, frames.head);
    put_word(OP_BYTE, 8'd0);
    put_word(OP_BYTE, frames.head);
    put_word(OP_BYTE, 8'd100);
    put_word(OP_BYTE, frames.head);
    put_word(OP_BYTE, 8'd2);
    put_word(OP_BYTE, 8'hFF);
    put_word(OP_BYTE, 8'h01);
    put_word(OP_BYTE, 8'h00);
    put_word(OP_BYTE, frames.head);
    put_word(OP_BYTE, 8'd1);
    put_word(OP_BYTE, 8'h80);
    put_word(OP_BYTE, 8'h00);
    settle();

    // Zero timeout: first tick while awaiting length gives up the frame
    write_cfg(CFG_TIMEOUT_TICKS, 8'd0);
    @(negedge clk);
    put_word(OP_BYTE, frames.head);
    put_word(OP_TICK, 8'h5A);
    settle();

    // Timeout in the middle of a payload
    write_cfg(CFG_TIMEOUT_TICKS, 8'd2);
    @(negedge clk);
    put_word(OP_BYTE, frames.head);
    put_word(OP_BYTE, 8'd3);
    put_word(OP_BYTE, 8'hAA);
    put_word(OP_TICK, 8'h00);
    put_word(OP_TICK, 8'hFF);

    // Random traffic under a range of settings, extremes first
    for (int p = 0; p < 6; p++) begin
      settle();
      case (p)
        0: load_cfg(8'h00, 8'hFF, 8'hFF);
        1: load_cfg(8'hFF, 8'd1, 8'd1);
        2: load_cfg(8'h55, 8'd0, 8'd0);
        3: load_cfg(8'($urandom_range(0, 255)), 8'($urandom_range(1, 40)),
                    8'($urandom_range(2, 30)));
        4: begin
          load_cfg(8'($urandom_range(0, 255)), 8'($urandom_range(1, 255)),
                   8'($urandom_range(1, 255)));
          write_cfg(CFG_SPARE, 8'($urandom_range(0, 255)));
        end
        default: load_cfg(HEAD_BYTE_RST, MAX_PAYLOAD_RST, TIMEOUT_TICKS_RST);
      endcase
      @(negedge clk);
      traffic_phase = p + 1;
      make_traffic(225);
    end
    settle();

    if (frames.errors == 0 && frames.pending_results.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
